// ===== rtl/bpl_pkg.sv =====
package bpl_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int SCORE_W     = 33;
    localparam int SUM_W       = 20;
    localparam int CONF_W      = 16;
    localparam int GRP         = 4;
    localparam int NUM_GRP     = (MAX_ENTRIES + GRP - 1) / GRP;
    localparam int PSUM_W      = CONF_W + $clog2(GRP);
    localparam int PADDR_W     = 3;

    localparam logic [15:0] Q_ONE     = 16'd32768;
    localparam logic [4:0]  CAP_RESET = 5'd16;

    localparam logic MODE_SUBMIT = 1'b0;
    localparam logic MODE_CLEAR  = 1'b1;

    localparam logic [PADDR_W-3:0] REG_CAPACITY = '0;

    typedef struct packed {
        logic        mode;
        logic [31:0] item_key;
        logic [31:0] item_time;
        logic [15:0] salience;
        logic [15:0] confidence;
        logic        inhibited;
    } t_req;

    typedef struct packed {
        logic        accepted;
        logic        retained;
        logic [4:0]  entry_count;
        logic [4:0]  admitted_count;
        logic [4:0]  inhibited_count;
        logic [19:0] confidence_sum;
        logic [31:0] top_key;
        logic        top_valid;
    } t_rsp;

    typedef struct packed {
        logic load;
        logic score;
        logic insert;
        logic sum;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

// ===== rtl/bpl_ctrl.sv =====
module bpl_ctrl
    import bpl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCORE  = 3'd1;
    localparam logic [2:0] S_INSERT = 3'd2;
    localparam logic [2:0] S_SUM    = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state     = r_state;
        o_req_ready = 1'b0;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCORE;
                end
            end
            S_SCORE: begin
                o_cmd.score = 1'b1;
                n_state     = S_INSERT;
            end
            S_INSERT: begin
                o_cmd.insert = 1'b1;
                n_state      = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                // hold the result until the output register frees, then take the next request
                if (i_sts.out_free) begin
                    o_cmd.emit  = 1'b1;
                    o_req_ready = 1'b1;
                    if (i_req_valid) begin
                        o_cmd.load = 1'b1;
                        n_state    = S_SCORE;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef ASSERT_OFF
    a_load_then_score: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_cmd.score)
        else $error("load not followed by score");

    a_insert_then_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.insert |=> o_cmd.sum)
        else $error("insert not followed by sum");

    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !i_sts.out_free) |=> (r_state == S_DONE && !$past(o_cmd.emit)))
        else $error("result left while output register busy");
`endif

endmodule

// ===== rtl/bpl_dpath.sv =====
module bpl_dpath
    import bpl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_req       i_req,
    input  logic [4:0] i_capacity,
    input  t_cmd       i_cmd,
    output t_sts       o_sts,
    output logic       o_rsp_valid,
    input  logic       i_rsp_ready,
    output t_rsp       o_rsp
);

    t_req                      r_req;
    logic signed [SCORE_W-1:0] r_score;
    logic [31:0]               r_key_q  [MAX_ENTRIES];
    logic [31:0]               r_time_q [MAX_ENTRIES];
    logic [CONF_W-1:0]         r_conf_q [MAX_ENTRIES];
    logic signed [SCORE_W-1:0] r_scr_q  [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0]    r_inh_q;
    logic [CNT_W-1:0]          r_occ;
    logic [CNT_W-1:0]          n_occ;
    logic [PSUM_W-1:0]         r_psum   [NUM_GRP];
    logic                      r_accepted;
    logic                      r_retained;
    t_rsp                      r_rsp;
    logic                      r_rsp_valid;

    logic [31:0]            prod;
    logic [CNT_W-1:0]       eff_cap;
    logic [IDX_W-1:0]       cap_idx;
    logic [MAX_ENTRIES-1:0] valid;
    logic [MAX_ENTRIES-1:0] keep;
    logic [MAX_ENTRIES-1:0] key_hit;
    logic                   bad;
    logic                   ins_ok;
    logic                   do_write;
    logic [CNT_W:0]         occ_inc;
    logic [CNT_W:0]         occ_cap;
    logic [SUM_W-1:0]       csum;

    assign prod = r_req.salience * r_req.confidence;

    always_comb begin
        if (i_capacity == 5'd0) begin
            eff_cap = CNT_W'(1);
        end else if (int'(i_capacity) > MAX_ENTRIES) begin
            eff_cap = CNT_W'(MAX_ENTRIES);
        end else begin
            eff_cap = CNT_W'(i_capacity);
        end
    end

    assign cap_idx = IDX_W'(eff_cap - CNT_W'(1));

    // per-cell compare: keep marks entries ranked at or above the new item
    for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cmp
        logic new_above;
        assign valid[i]   = CNT_W'(i) < r_occ;
        assign new_above  = (r_score > r_scr_q[i]) ||
                            ((r_score == r_scr_q[i]) && (r_req.item_time < r_time_q[i]));
        assign keep[i]    = valid[i] && !new_above;
        assign key_hit[i] = valid[i] && (r_key_q[i] == r_req.item_key);
    end

    assign bad      = (r_req.salience > Q_ONE) || (r_req.confidence > Q_ONE) || (|key_hit);
    assign ins_ok   = (r_req.mode == MODE_SUBMIT) && !bad;
    // keep is a prefix, so the insert point lies below capacity when the last slot within capacity is not kept
    assign do_write = ins_ok && !keep[cap_idx];
    assign occ_inc  = {1'b0, r_occ} + (CNT_W+1)'(1);
    assign occ_cap  = {1'b0, eff_cap};

    always_comb begin
        n_occ = r_occ;
        if (r_req.mode == MODE_CLEAR) begin
            n_occ = '0;
        end else if (ins_ok) begin
            if (do_write) begin
                n_occ = (occ_inc > occ_cap) ? eff_cap : CNT_W'(occ_inc);
            end else begin
                n_occ = (r_occ > eff_cap) ? eff_cap : r_occ;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        if (i_cmd.score) begin
            r_score <= r_req.inhibited ? {SCORE_W{1'b1}} : signed'({1'b0, prod});
        end
        if (i_cmd.insert) begin
            r_accepted <= ins_ok;
            r_retained <= do_write;
        end
    end

    for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
        logic take_new;
        if (i == 0) begin : g_head
            assign take_new = 1'b1;
        end else begin : g_body
            assign take_new = keep[i-1];
        end

        always_ff @(posedge i_clk) begin
            if (i_cmd.insert && do_write && !keep[i]) begin
                if (take_new) begin
                    r_key_q[i]  <= r_req.item_key;
                    r_time_q[i] <= r_req.item_time;
                    r_conf_q[i] <= r_req.confidence;
                    r_scr_q[i]  <= r_score;
                    r_inh_q[i]  <= r_req.inhibited;
                end else if (i > 0) begin
                    // shift down from the cell above
                    r_key_q[i]  <= r_key_q[(i > 0) ? i - 1 : 0];
                    r_time_q[i] <= r_time_q[(i > 0) ? i - 1 : 0];
                    r_conf_q[i] <= r_conf_q[(i > 0) ? i - 1 : 0];
                    r_scr_q[i]  <= r_scr_q[(i > 0) ? i - 1 : 0];
                    r_inh_q[i]  <= r_inh_q[(i > 0) ? i - 1 : 0];
                end
            end
        end
    end

    function automatic logic [PSUM_W-1:0] grp_sum(input int g);
        logic [PSUM_W-1:0] acc;
        acc = '0;
        for (int k = 0; k < GRP; k++) begin
            if (g * GRP + k < MAX_ENTRIES) begin
                if (valid[g * GRP + k] && !r_inh_q[g * GRP + k]) begin
                    acc = acc + PSUM_W'(r_conf_q[g * GRP + k]);
                end
            end
        end
        return acc;
    endfunction

    // confidence sum in two registered levels: groups, then total
    always_ff @(posedge i_clk) begin
        if (i_cmd.sum) begin
            for (int g = 0; g < NUM_GRP; g++) begin
                r_psum[g] <= grp_sum(g);
            end
        end
    end

    always_comb begin
        csum = '0;
        for (int g = 0; g < NUM_GRP; g++) begin
            csum = csum + SUM_W'(r_psum[g]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ       <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (i_cmd.insert) begin
                r_occ <= n_occ;
            end
            if (i_cmd.emit) begin
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_rsp.accepted        <= r_accepted;
            r_rsp.retained        <= r_retained;
            r_rsp.entry_count     <= 5'(r_occ);
            r_rsp.admitted_count  <= 5'($countones(valid & ~r_inh_q));
            r_rsp.inhibited_count <= 5'($countones(valid & r_inh_q));
            r_rsp.confidence_sum  <= csum;
            r_rsp.top_key         <= (r_occ != '0) ? r_key_q[0] : 32'd0;
            r_rsp.top_valid       <= (r_occ != '0);
        end
    end

    assign o_sts.out_free = !r_rsp_valid || i_rsp_ready;
    assign o_rsp_valid    = r_rsp_valid;
    assign o_rsp          = r_rsp;

`ifndef ASSERT_OFF
    a_occ_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.insert && ins_ok) |=> (r_occ <= eff_cap))
        else $error("occupancy above capacity after insert");

    a_counts_add_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> (o_rsp_valid &&
            (o_rsp.admitted_count + o_rsp.inhibited_count == o_rsp.entry_count)))
        else $error("admitted and inhibited counts disagree with entry count");

    a_top_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> (o_rsp.top_valid == (o_rsp.entry_count != 5'd0)))
        else $error("top_valid disagrees with entry count");
`endif

endmodule

// ===== rtl/bounded_priority_top_k_list_unit.sv =====
// Bounded priority list: keeps up to list_capacity entries (clamped to
// 1..16) sorted by salience*confidence (inhibited entries score below all
// others), with earlier item_time winning ties.
// Request channel: i_req_valid / o_req_ready carry one t_req (submit or
// clear). Response channel: o_rsp_valid / i_rsp_ready carry one t_rsp per
// request, describing the list after that request.
// Processing: an accepted request passes through the score multiply, the
// compare and shift of the entry cells, the group sums of confidence and
// the final sum into the output register before its response is valid.
// The next request is taken in the same cycle that the previous response
// is loaded into the output register.
// The response register holds its result while i_rsp_ready is low; a new
// request may still be accepted, and its result waits until the response
// register is taken.
// Configuration: APB register 0 (byte address 0) is list_capacity, 5 bits,
// reset 16; write it only while the block is idle.
// Reset (synchronous, active low) empties the list and drops any response.
module bounded_priority_top_k_list_unit
    import bpl_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    output logic               o_req_ready,
    input  t_req               i_req,
    output logic               o_rsp_valid,
    input  logic               i_rsp_ready,
    output t_rsp               o_rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [4:0] r_capacity;
    logic       reg_sel;
    t_cmd       cmd;
    t_sts       sts;

    assign reg_sel = (paddr[PADDR_W-1:2] == REG_CAPACITY);
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? 32'(r_capacity) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (psel && penable && pwrite && reg_sel) begin
            r_capacity <= pwdata[4:0];
        end
    end

    bpl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    bpl_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_capacity  (r_capacity),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

endmodule
